[src/rtb_pkg.sv]
// ----------------------------------------------------------------------------
// rtb_pkg
// Shared widths, reset values, register indexes and stage records for the
// per-target retry backoff gate.
// ----------------------------------------------------------------------------
`default_nettype none

package rtb_pkg;

   localparam int TARGET_W    = 3;
   localparam int TIME_W      = 48;
   localparam int DELAY_W     = 27;
   localparam int GEN_W       = 16;
   localparam int MINR_W      = 20;
   localparam int MAXB_W      = 27;
   localparam int CAP_W       = 4;
   localparam int JIT_W       = 13;
   localparam int RETRY_W     = 27;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 27;
   localparam int TARGET_SPAN = 1 << TARGET_W;

   localparam logic [MINR_W-1:0]  MIN_RETRY_RESET   = MINR_W'(60000);
   localparam logic [MAXB_W-1:0]  MAX_BACKOFF_RESET = MAXB_W'(15 * 60000);
   localparam logic [CAP_W-1:0]   FAILURE_CAP_RESET = CAP_W'(5);
   localparam logic [RETRY_W-1:0] MAX_DELAY_MS      = RETRY_W'(24 * 60 * 60000);
   localparam logic [TIME_W-1:0]  TIME_MAX          = '1;
   localparam logic [DELAY_W-1:0] DELAY_FIELD_MAX   = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RETRY   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BACKOFF = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FAILURE_CAP = 2'd2;

   localparam logic ACT_ADMIT    = 1'b0;
   localparam logic ACT_COMPLETE = 1'b1;

   typedef struct packed {
      logic [MINR_W-1:0] min_retry;
      logic [MAXB_W-1:0] max_backoff;
      logic [CAP_W-1:0]  failure_cap;
   } cfg_type;

   // registered request with the state-independent sums already formed
   typedef struct packed {
      logic                action;
      logic                tracked;
      logic [TARGET_W-1:0] target;
      logic [TIME_W-1:0]   now;
      logic [TIME_W:0]     now_jitter;
      logic [TIME_W-1:0]   floor;
      logic [GEN_W-1:0]    agen;
      logic                aprobe;
      logic                failed;
      logic                canceled;
   } req_type;

   typedef struct packed {
      logic [TIME_W-1:0] deadline;
      logic [TIME_W-1:0] now;
      logic [MINR_W-1:0] min_retry;
      logic              sel_min;
      logic [GEN_W-1:0]  generation;
      logic              probe;
   } upd_type;

endpackage

`default_nettype wire

[src/rtb_csr.sv]
// ----------------------------------------------------------------------------
// rtb_csr
// Configuration registers: base retry delay, backoff ceiling, failure cap.
// ----------------------------------------------------------------------------
`default_nettype none

module rtb_csr
   import rtb_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   logic [MINR_W-1:0] min_retry_ff, min_retry_in;
   logic [MAXB_W-1:0] max_backoff_ff, max_backoff_in;
   logic [CAP_W-1:0]  failure_cap_ff, failure_cap_in;

   assign csr_ready = 1'b1;

   always_comb begin
      min_retry_in   = min_retry_ff;
      max_backoff_in = max_backoff_ff;
      failure_cap_in = failure_cap_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MIN_RETRY:   min_retry_in   = csr_wdata[MINR_W-1:0];
            CSR_MAX_BACKOFF: max_backoff_in = csr_wdata[MAXB_W-1:0];
            CSR_FAILURE_CAP: failure_cap_in = csr_wdata[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_retry_ff   <= MIN_RETRY_RESET;
         max_backoff_ff <= MAX_BACKOFF_RESET;
         failure_cap_ff <= FAILURE_CAP_RESET;
      end else begin
         min_retry_ff   <= min_retry_in;
         max_backoff_ff <= max_backoff_in;
         failure_cap_ff <= failure_cap_in;
      end
   end

   assign cfg.min_retry   = min_retry_ff;
   assign cfg.max_backoff = max_backoff_ff;
   assign cfg.failure_cap = failure_cap_ff;

endmodule

`default_nettype wire

[src/rtb_update.sv]
// ----------------------------------------------------------------------------
// rtb_update
// Per-target entry table and its read-modify-write, all in the same cycle:
// admit decision, probe release, failure backoff and server delay floor.
// ----------------------------------------------------------------------------
`default_nettype none

module rtb_update
   import rtb_pkg::*;
#(
   parameter int TARGETS = 8
)
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire req_type req,
   input  wire cfg_type cfg,
   output logic         upd_valid,
   output upd_type      upd
);

   // only indexes the target field can reach need storage
   localparam int ENTRIES = (TARGETS < TARGET_SPAN) ? TARGETS : TARGET_SPAN;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int SHIFT_W = MINR_W + (1 << CAP_W) - 1;

   logic [TIME_W-1:0] deadline_ff [ENTRIES];
   logic [CAP_W-1:0]  fail_ff     [ENTRIES];
   logic [GEN_W-1:0]  gen_ff      [ENTRIES];
   logic              busy_ff     [ENTRIES];

   logic    upd_valid_ff;
   upd_type upd_ff, upd_in;

   logic [IDX_W-1:0]   idx;
   logic [TIME_W-1:0]  dl_cur, dl_new, dl_mid, dl_fail;
   logic [CAP_W-1:0]   fc_cur, fc_new, cap_eff, f_new;
   logic [CAP_W:0]     f_inc;
   logic [GEN_W-1:0]   gen_cur, gen_new;
   logic               busy_cur, busy_new;
   logic               expired, gen_match, sel_min, probe_grant, wr_en;
   logic [SHIFT_W-1:0] shifted;
   logic [MAXB_W-1:0]  backoff;
   logic [TIME_W+1:0]  bsum;

   assign idx      = req.target[IDX_W-1:0];
   assign dl_cur   = deadline_ff[idx];
   assign fc_cur   = fail_ff[idx];
   assign gen_cur  = gen_ff[idx];
   assign busy_cur = busy_ff[idx];

   assign expired   = req.now >= dl_cur;
   assign gen_match = req.agen == gen_cur;

   // a zero cap acts as one
   assign cap_eff = (cfg.failure_cap == '0) ? CAP_W'(1) : cfg.failure_cap;
   assign f_inc   = {1'b0, fc_cur} + (CAP_W+1)'(1);
   assign f_new   = (f_inc > {1'b0, cap_eff}) ? cap_eff : f_inc[CAP_W-1:0];

   assign shifted = SHIFT_W'(cfg.min_retry) << (f_new - CAP_W'(1));
   assign backoff = (shifted > SHIFT_W'(cfg.max_backoff)) ? cfg.max_backoff
                                                          : shifted[MAXB_W-1:0];

   // jitter is already folded into now_jitter; one saturation covers both adds
   assign bsum    = {1'b0, req.now_jitter} + (TIME_W+2)'(backoff);
   assign dl_fail = (bsum[TIME_W+1:TIME_W] != 2'b00) ? TIME_MAX : bsum[TIME_W-1:0];

   always_comb begin
      dl_new      = dl_cur;
      dl_mid      = dl_cur;
      fc_new      = fc_cur;
      gen_new     = gen_cur;
      busy_new    = busy_cur;
      sel_min     = 1'b0;
      probe_grant = 1'b0;
      if (req.action == ACT_ADMIT) begin
         if (expired) begin
            if (busy_cur) begin
               sel_min = 1'b1;
            end else begin
               busy_new    = fc_cur != '0;
               probe_grant = fc_cur != '0;
            end
         end
      end else begin
         if (req.aprobe && gen_match) begin
            busy_new = 1'b0;
         end
         if (!req.canceled) begin
            if (!req.failed) begin
               if (gen_match && expired) begin
                  fc_new = '0;
               end
            end else begin
               // failure while still cooling down only honors the server floor
               if (expired) begin
                  fc_new   = f_new;
                  gen_new  = gen_cur + GEN_W'(1);
                  busy_new = 1'b0;
                  dl_mid   = dl_fail;
               end
               dl_new = (dl_mid < req.floor) ? req.floor : dl_mid;
            end
         end
      end
   end

   assign wr_en = req_valid && req.tracked;

   always_comb begin
      upd_in.deadline   = req.tracked ? dl_new : '0;
      upd_in.now        = req.now;
      upd_in.min_retry  = cfg.min_retry;
      upd_in.sel_min    = req.tracked && sel_min;
      upd_in.generation = req.tracked ? gen_new : '0;
      upd_in.probe      = req.tracked && probe_grant;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            deadline_ff[i] <= '0;
            fail_ff[i]     <= '0;
            gen_ff[i]      <= '0;
            busy_ff[i]     <= 1'b0;
         end
      end else if (wr_en) begin
         deadline_ff[idx] <= dl_new;
         fail_ff[idx]     <= fc_new;
         gen_ff[idx]      <= gen_new;
         busy_ff[idx]     <= busy_new;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upd_valid_ff <= 1'b0;
      end else begin
         upd_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      upd_ff <= upd_in;
   end

   assign upd_valid = upd_valid_ff;
   assign upd       = upd_ff;

   // a granted probe leaves the entry marked as having one outstanding
   a_probe_marks_busy: assert property (@(posedge clock) disable iff (reset)
      (wr_en && probe_grant) |=> busy_ff[$past(idx)])
      else $error("probe granted but entry not marked busy");

   // a granted probe never carries a delay
   a_probe_no_delay: assert property (@(posedge clock) disable iff (reset)
      (upd_valid_ff && upd_ff.probe) |-> (!upd_ff.sel_min && upd_ff.deadline <= upd_ff.now))
      else $error("probe granted while target still cooling down");

   for (genvar g = 0; g < ENTRIES; g++) begin : g_gen_chk
      a_gen_step: assert property (@(posedge clock) disable iff (reset)
         $past(!reset) |-> (gen_ff[g] == $past(gen_ff[g]) ||
                            gen_ff[g] == $past(gen_ff[g]) + GEN_W'(1)))
         else $error("generation moved by more than one in a cycle");
   end

endmodule

`default_nettype wire

[src/rtb_rsp.sv]
// ----------------------------------------------------------------------------
// rtb_rsp
// Result stage: cooldown left from the updated deadline, saturated to the
// delay field, and the busy-probe delay selection.
// ----------------------------------------------------------------------------
`default_nettype none

module rtb_rsp
   import rtb_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          upd_valid,
   input  wire upd_type       upd,
   output logic               rsp_valid,
   output logic [DELAY_W-1:0] rsp_delay_ms,
   output logic [GEN_W-1:0]   rsp_generation,
   output logic               rsp_probe
);

   logic               rsp_valid_ff;
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [GEN_W-1:0]   gen_ff;
   logic               probe_ff;
   logic [TIME_W-1:0]  diff;
   logic [DELAY_W-1:0] left;

   assign diff = upd.deadline - upd.now;

   always_comb begin
      if (upd.deadline <= upd.now) begin
         left = '0;
      end else if (diff[TIME_W-1:DELAY_W] != '0) begin
         left = DELAY_FIELD_MAX;
      end else begin
         left = diff[DELAY_W-1:0];
      end
      delay_in = upd.sel_min ? DELAY_W'(upd.min_retry) : left;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= upd_valid;
      end
   end

   always_ff @(posedge clock) begin
      delay_ff <= delay_in;
      gen_ff   <= upd.generation;
      probe_ff <= upd.probe;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_delay_ms   = delay_ff;
   assign rsp_generation = gen_ff;
   assign rsp_probe      = probe_ff;

endmodule

`default_nettype wire

[src/per_target_retry_backoff.sv]
// ----------------------------------------------------------------------------
// per_target_retry_backoff
// Per-target retry gate with exponential backoff and one half-open probe.
// ----------------------------------------------------------------------------
// A transaction is taken at every clock edge with start high; busy stays low,
// so one admit or completion can be issued every cycle. Each transaction
// gives exactly one result, strobed on rsp_valid for one cycle, in issue
// order after it passes the input register, entry update and result
// register. The result side cannot stall, so the receiver must take every
// strobe. The per-target entry table is read, updated and written back
// in the same cycle, which lets consecutive transactions hit the same
// target without a gap. The table sits in flip-flops cleared by reset, so
// the block is usable right after reset. Configuration writes are accepted
// every cycle and should only be issued while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module per_target_retry_backoff
   import rtb_pkg::*;
#(
   parameter int TARGETS = 8
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_action,
   input  wire logic [TARGET_W-1:0]   req_target,
   input  wire logic [TIME_W-1:0]     req_now_ms,
   input  wire logic [GEN_W-1:0]      req_admitted_generation,
   input  wire logic                  req_admitted_probe,
   input  wire logic                  req_failed,
   input  wire logic                  req_canceled,
   input  wire logic [RETRY_W-1:0]    req_retry_after_ms,
   input  wire logic [JIT_W-1:0]      req_jitter_ms,
   output logic                       rsp_valid,
   output logic [DELAY_W-1:0]         rsp_delay_ms,
   output logic [GEN_W-1:0]           rsp_generation,
   output logic                       rsp_probe,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   logic    req_valid_ff;
   req_type req_ff, req_in;

   logic [RETRY_W-1:0] retry_clamped;
   logic [TIME_W:0]    floor_sum;

   logic    upd_valid;
   upd_type upd;

   assign busy = 1'b0;

   rtb_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // server delay floor and now plus jitter need no entry state
   assign retry_clamped = (req_retry_after_ms > MAX_DELAY_MS) ? MAX_DELAY_MS
                                                              : req_retry_after_ms;
   assign floor_sum     = {1'b0, req_now_ms} + (TIME_W+1)'(retry_clamped);

   always_comb begin
      req_in.action     = req_action;
      req_in.tracked    = 32'(req_target) < TARGETS;
      req_in.target     = req_target;
      req_in.now        = req_now_ms;
      req_in.now_jitter = {1'b0, req_now_ms} + (TIME_W+1)'(req_jitter_ms);
      req_in.floor      = floor_sum[TIME_W] ? TIME_MAX : floor_sum[TIME_W-1:0];
      req_in.agen       = req_admitted_generation;
      req_in.aprobe     = req_admitted_probe;
      req_in.failed     = req_failed;
      req_in.canceled   = req_canceled;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
   end

   rtb_update #(
      .TARGETS (TARGETS)
   ) u_update (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid_ff),
      .req       (req_ff),
      .cfg       (cfg),
      .upd_valid (upd_valid),
      .upd       (upd)
   );

   rtb_rsp u_rsp (
      .clock          (clock),
      .reset          (reset),
      .upd_valid      (upd_valid),
      .upd            (upd),
      .rsp_valid      (rsp_valid),
      .rsp_delay_ms   (rsp_delay_ms),
      .rsp_generation (rsp_generation),
      .rsp_probe      (rsp_probe)
   );

   // every strobe traces back to an accepted transaction that passed the input, update and result registers
   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, 3))
      else $error("result strobe without a matching transaction");

endmodule

`default_nettype wire

[dv/per_target_retry_backoff_tb.sv]
// ----------------------------------------------------------------------------
// per_target_retry_backoff_tb
// Self-checking bench for the per-target retry backoff gate. A directed table
// covers reset state, probe handoff, stale releases, cooldown failures and
// the time and delay saturation corners; random phases then run admit and
// completion traffic under several register settings. Every result is
// compared in order against a typed row or a cycle-free target table model.
// ----------------------------------------------------------------------------
`default_nettype none

module per_target_retry_backoff_tb;
   import rtb_pkg::*;

   localparam int HALF_PERIOD    = 10;
   localparam int RESET_CYCLES   = 11;
   localparam int PIPE_DEPTH     = 3;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 100;
   localparam int MAX_TICKETS    = 24;

   // unmapped register index, writes must be dropped
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE = 2'd3;

   typedef struct packed {
      logic                action;
      logic [TARGET_W-1:0] target;
      logic [TIME_W-1:0]   now;
      logic [GEN_W-1:0]    agen;
      logic                aprobe;
      logic                failed;
      logic                canceled;
      logic [RETRY_W-1:0]  retry;
      logic [JIT_W-1:0]    jitter;
   } gate_req_type;

   typedef struct packed {
      logic [DELAY_W-1:0] delay;
      logic [GEN_W-1:0]   generation;
      logic               probe;
   } gate_reply_type;

   typedef struct packed {
      gate_req_type   req;
      logic           typed;
      gate_reply_type want;
   } script_row_type;

   // an admitted request still waiting to report its completion
   typedef struct packed {
      logic [TARGET_W-1:0] target;
      logic [GEN_W-1:0]    generation;
      logic                probe;
   } ticket_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic                  req_action;
   logic [TARGET_W-1:0]   req_target;
   logic [TIME_W-1:0]     req_now_ms;
   logic [GEN_W-1:0]      req_admitted_generation;
   logic                  req_admitted_probe;
   logic                  req_failed;
   logic                  req_canceled;
   logic [RETRY_W-1:0]    req_retry_after_ms;
   logic [JIT_W-1:0]      req_jitter_ms;
   logic                  rsp_valid;
   logic [DELAY_W-1:0]    rsp_delay_ms;
   logic [GEN_W-1:0]      rsp_generation;
   logic                  rsp_probe;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   // model of the target table and registers
   logic [TIME_W-1:0] cool_until [TARGET_SPAN];
   logic [CAP_W-1:0]  strikes    [TARGET_SPAN];
   logic [GEN_W-1:0]  epoch      [TARGET_SPAN];
   logic              probe_out  [TARGET_SPAN];
   logic [MINR_W-1:0] cfg_min_retry;
   logic [MAXB_W-1:0] cfg_max_backoff;
   logic [CAP_W-1:0]  cfg_fail_cap;

   gate_reply_type replies_due [$];
   script_row_type directed_rows [$];
   ticket_type     open_tickets [$];
   gate_reply_type head_reply;
   logic [TIME_W-1:0] wall_ms;
   int unsigned faults;
   int unsigned quiet_cycles;

   per_target_retry_backoff uut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_action              (req_action),
      .req_target              (req_target),
      .req_now_ms              (req_now_ms),
      .req_admitted_generation (req_admitted_generation),
      .req_admitted_probe      (req_admitted_probe),
      .req_failed              (req_failed),
      .req_canceled            (req_canceled),
      .req_retry_after_ms      (req_retry_after_ms),
      .req_jitter_ms           (req_jitter_ms),
      .rsp_valid               (rsp_valid),
      .rsp_delay_ms            (rsp_delay_ms),
      .rsp_generation          (rsp_generation),
      .rsp_probe               (rsp_probe),
      .csr_valid               (csr_valid),
      .csr_ready               (csr_ready),
      .csr_index               (csr_index),
      .csr_wdata               (csr_wdata)
   );

   always #(HALF_PERIOD) clock = ~clock;

   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                 input logic [TIME_W-1:0] b);
      logic [TIME_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
   endfunction

   function automatic logic [DELAY_W-1:0] cooldown(input logic [TARGET_W-1:0] t,
                                                   input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] d;
      if (cool_until[t] <= now) return '0;
      d = cool_until[t] - now;
      return (d > TIME_W'(DELAY_FIELD_MAX)) ? DELAY_FIELD_MAX : d[DELAY_W-1:0];
   endfunction

   // applies one transaction to the table model and returns its result
   function automatic gate_reply_type gate_update(input gate_req_type it);
      gate_reply_type      r;
      logic [TARGET_W-1:0] t;
      logic [63:0]         backoff;
      logic [RETRY_W-1:0]  retry;
      logic [TIME_W-1:0]   floor_ms;
      int unsigned         cap;
      int unsigned         f;
      logic                expired;
      t = it.target;
      r = '0;
      r.generation = epoch[t];
      if (it.action == ACT_ADMIT) begin
         r.delay = cooldown(t, it.now);
         if (r.delay == '0) begin
            if (probe_out[t]) begin
               r.delay = DELAY_W'(cfg_min_retry);
            end else begin
               probe_out[t] = (strikes[t] != '0);
               r.probe = probe_out[t];
            end
         end
         return r;
      end
      if (it.aprobe && it.agen == epoch[t]) probe_out[t] = 1'b0;
      if (!it.canceled) begin
         expired = (it.now >= cool_until[t]);
         if (!it.failed) begin
            if (it.agen == epoch[t] && expired) strikes[t] = '0;
         end else begin
            // a failure inside the cooldown only honors the server delay
            if (expired) begin
               cap = (cfg_fail_cap == '0) ? 1 : cfg_fail_cap;
               f = strikes[t] + 1;
               if (f > cap) f = cap;
               strikes[t] = CAP_W'(f);
               epoch[t] = epoch[t] + 1'b1;
               probe_out[t] = 1'b0;
               backoff = 64'(cfg_min_retry) << (f - 1);
               if (backoff > 64'(cfg_max_backoff)) backoff = 64'(cfg_max_backoff);
               cool_until[t] = sat_add(sat_add(it.now, backoff[TIME_W-1:0]),
                                       TIME_W'(it.jitter));
            end
            retry = (it.retry > MAX_DELAY_MS) ? MAX_DELAY_MS : it.retry;
            floor_ms = sat_add(it.now, TIME_W'(retry));
            if (cool_until[t] < floor_ms) cool_until[t] = floor_ms;
         end
      end
      r.delay = cooldown(t, it.now);
      r.generation = epoch[t];
      r.probe = 1'b0;
      return r;
   endfunction

   function automatic void add_row(input logic a, input int unsigned tgt,
                                   input logic [TIME_W-1:0] now, input int unsigned agen,
                                   input logic ap, input logic fl, input logic cn,
                                   input logic [RETRY_W-1:0] retry,
                                   input logic [JIT_W-1:0] jit, input logic typed,
                                   input logic [DELAY_W-1:0] d, input int unsigned g,
                                   input logic p);
      script_row_type row;
      row.req = '{a, TARGET_W'(tgt), now, GEN_W'(agen), ap, fl, cn, retry, jit};
      row.typed = typed;
      row.want = '{d, GEN_W'(g), p};
      directed_rows.push_back(row);
   endfunction

   task automatic issue(input gate_req_type it, input logic typed,
                        input gate_reply_type want, output gate_reply_type got);
      req_action              <= it.action;
      req_target              <= it.target;
      req_now_ms              <= it.now;
      req_admitted_generation <= it.agen;
      req_admitted_probe      <= it.aprobe;
      req_failed              <= it.failed;
      req_canceled            <= it.canceled;
      req_retry_after_ms      <= it.retry;
      req_jitter_ms           <= it.jitter;
      start                   <= 1'b1;
      do @(posedge clock); while (busy);
      got = gate_update(it);
      replies_due.push_back(typed ? want : got);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (replies_due.size() != 0) @(posedge clock);
      repeat (PIPE_DEPTH + 1) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_MIN_RETRY:   cfg_min_retry = data[MINR_W-1:0];
         CSR_MAX_BACKOFF: cfg_max_backoff = data[MAXB_W-1:0];
         CSR_FAILURE_CAP: cfg_fail_cap = data[CAP_W-1:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input int unsigned count);
      gate_req_type   it;
      gate_reply_type got;
      ticket_type     tk;
      int unsigned    n;
      int unsigned    roll;
      int unsigned    pick;
      int unsigned    gap;
      logic           no_idle;
      no_idle = ($urandom_range(0, 3) == 0);
      // step past every unsaturated deadline left by the previous setting
      wall_ms = wall_ms + TIME_W'(200000000);
      for (n = 0; n < count; n++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) begin
            wall_ms = wall_ms + TIME_W'($urandom_range(0, cfg_min_retry));
         end else if (pick < 9) begin
            wall_ms = wall_ms + TIME_W'($urandom_range(0, cfg_max_backoff + 6000));
         end
         it = '0;
         it.target = TARGET_W'($urandom_range(0, TARGET_SPAN - 1));
         it.now = wall_ms;
         pick = $urandom_range(0, 99);
         if (pick < 60) it.retry = '0;
         else if (pick < 90) it.retry = RETRY_W'($urandom_range(0, 2 * cfg_min_retry));
         else if (pick < 97) it.retry = RETRY_W'($urandom_range(0, MAX_DELAY_MS));
         else it.retry = RETRY_W'($urandom);
         it.jitter = ($urandom_range(0, 9) == 0) ? JIT_W'($urandom)
                                                  : JIT_W'($urandom_range(0, 6000));
         roll = $urandom_range(0, 99);
         if (roll < 45 || open_tickets.size() == 0) begin
            it.action = ACT_ADMIT;
         end else if (roll < 88) begin
            // completion of a request that was really admitted
            pick = $urandom_range(0, open_tickets.size() - 1);
            tk = open_tickets[pick];
            open_tickets.delete(pick);
            it.action = ACT_COMPLETE;
            it.target = tk.target;
            it.agen = tk.generation;
            it.aprobe = tk.probe;
            it.failed = 1'($urandom_range(0, 1));
            it.canceled = ($urandom_range(0, 9) == 0);
         end else begin
            it.action = 1'($urandom_range(0, 1));
            it.agen = GEN_W'($urandom);
            it.aprobe = 1'($urandom_range(0, 1));
            it.failed = 1'($urandom_range(0, 1));
            it.canceled = 1'($urandom_range(0, 1));
            // far-off times only where they leave no deadline behind
            if (it.action == ACT_ADMIT || it.canceled) it.now = TIME_W'({$urandom, $urandom});
         end
         issue(it, 1'b0, '0, got);
         if (it.action == ACT_ADMIT) begin
            open_tickets.push_back('{it.target, got.generation, got.probe});
            if (open_tickets.size() > MAX_TICKETS) void'(open_tickets.pop_front());
         end
         if (!no_idle) begin
            pick = $urandom_range(0, 99);
            if (pick < 65) gap = 0;
            else if (pick < 88) gap = $urandom_range(1, 3);
            else if (pick < 97) gap = $urandom_range(4, 12);
            else gap = $urandom_range(20, 60);
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         if ($urandom_range(0, 199) == 0) wait_drained();
      end
   endtask

   function automatic void note_fault(input string msg);
      if (faults < 10) $display("%0t: %s", $time, msg);
      faults++;
   endfunction

   // response checker and watchdog
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid) begin
            if (replies_due.size() == 0) begin
               note_fault($sformatf("unexpected result delay %0d gen %0d probe %0b",
                                    rsp_delay_ms, rsp_generation, rsp_probe));
            end else begin
               head_reply = replies_due.pop_front();
               if (rsp_delay_ms !== head_reply.delay
                   || rsp_generation !== head_reply.generation
                   || rsp_probe !== head_reply.probe) begin
                  note_fault($sformatf({"mismatch: expected delay %0d gen %0d probe %0b, ",
                                        "got delay %0d gen %0d probe %0b"},
                                       head_reply.delay, head_reply.generation,
                                       head_reply.probe, rsp_delay_ms, rsp_generation,
                                       rsp_probe));
               end
            end
         end
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   initial begin
      gate_reply_type got;
      int unsigned    i;
      int unsigned    ph;
      faults = 0;
      wall_ms = '0;
      cfg_min_retry = MIN_RETRY_RESET;
      cfg_max_backoff = MAX_BACKOFF_RESET;
      cfg_fail_cap = FAILURE_CAP_RESET;
      for (i = 0; i < TARGET_SPAN; i++) begin
         cool_until[i] = '0;
         strikes[i] = '0;
         epoch[i] = '0;
         probe_out[i] = 1'b0;
      end

      // act, tgt, now, agen, aprobe, failed, canceled, retry, jitter, typed, d, gen, probe
      add_row(ACT_ADMIT, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      add_row(ACT_ADMIT, 7, TIME_MAX, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0);
      // first failure, then cooldown, probe grant and busy probe
      add_row(ACT_COMPLETE, 1, 1000, 0, 0, 1, 0, 0, 0, 1, 60000, 1, 0);
      add_row(ACT_ADMIT, 1, 2000, 0, 0, 0, 0, 0, 0, 1, 59000, 1, 0);
      add_row(ACT_ADMIT, 1, 61000, 0, 0, 0, 0, 0, 0, 1, 0, 1, 1);
      add_row(ACT_ADMIT, 1, 61001, 0, 0, 0, 0, 0, 0, 1, 60000, 1, 0);
      add_row(ACT_COMPLETE, 1, 61002, 1, 1, 0, 0, 0, 0, 1, 0, 1, 0);
      add_row(ACT_ADMIT, 1, 61003, 0, 0, 0, 0, 0, 0, 1, 0, 1, 0);
      // failure during cooldown only moves the deadline to the server delay
      add_row(ACT_COMPLETE, 2, 5000, 0, 0, 1, 0, 0, 6000, 1, 66000, 1, 0);
      add_row(ACT_COMPLETE, 2, 6000, 0, 0, 1, 0, 100000, 0, 1, 100000, 1, 0);
      // server delay above the day limit is clamped
      add_row(ACT_COMPLETE, 3, 0, 0, 0, 1, 0, '1, '1, 1, 86400000, 1, 0);
      add_row(ACT_COMPLETE, 3, 10, 0, 0, 0, 0, 0, 0, 1, 86399990, 1, 0);
      add_row(ACT_COMPLETE, 3, 20, 1, 1, 1, 1, 0, 0, 1, 86399980, 1, 0);
      // probe release with an old generation leaves the probe held
      add_row(ACT_COMPLETE, 4, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_ADMIT, 4, 60000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_COMPLETE, 4, 60001, 0, 1, 0, 1, 0, 0, 0, 0, 0, 0);
      add_row(ACT_ADMIT, 4, 60002, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      // deadline sum saturates, then a read from far back saturates the delay
      add_row(ACT_COMPLETE, 5, TIME_MAX - 10, 0, 0, 1, 0, 0, '1, 1, 10, 1, 0);
      add_row(ACT_ADMIT, 5, 0, 0, 0, 0, 0, 0, 0, 1, DELAY_FIELD_MAX, 1, 0);
      add_row(ACT_COMPLETE, 6, TIME_MAX, 16'hFFFF, 1, 1, 1, '1, '1, 1, 0, 0, 0);
      // back-to-back failures double the backoff, early success is stale
      add_row(ACT_COMPLETE, 1, 100000, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_COMPLETE, 1, 200000, 2, 0, 1, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_COMPLETE, 1, 200001, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0);
      add_row(ACT_COMPLETE, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

      reset <= 1'b1;
      start <= 1'b0;
      req_action <= ACT_ADMIT;
      req_target <= '0;
      req_now_ms <= '0;
      req_admitted_generation <= '0;
      req_admitted_probe <= 1'b0;
      req_failed <= 1'b0;
      req_canceled <= 1'b0;
      req_retry_after_ms <= '0;
      req_jitter_ms <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_MIN_RETRY;
      csr_wdata <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < directed_rows.size(); i++) begin
         issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want, got);
         if ($urandom_range(0, 1) == 0) begin
            start <= 1'b0;
            @(posedge clock);
         end
      end

      write_csr(CSR_MIN_RETRY, 1);
      write_csr(CSR_MAX_BACKOFF, 1);
      write_csr(CSR_FAILURE_CAP, 1);
      run_phase(PHASE_ITEMS);
      write_csr(CSR_MIN_RETRY, 600000);
      write_csr(CSR_MAX_BACKOFF, 86400000);
      write_csr(CSR_FAILURE_CAP, 15);
      run_phase(PHASE_ITEMS);
      // zero cap acts as a cap of one
      write_csr(CSR_MIN_RETRY, 37);
      write_csr(CSR_MAX_BACKOFF, 5000);
      write_csr(CSR_FAILURE_CAP, 0);
      write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
      run_phase(PHASE_ITEMS);
      for (ph = 0; ph < 5; ph++) begin
         write_csr(CSR_MIN_RETRY, CSR_DATA_W'($urandom_range(1, 2000)));
         write_csr(CSR_MAX_BACKOFF, CSR_DATA_W'($urandom_range(1, 200000)));
         write_csr(CSR_FAILURE_CAP, CSR_DATA_W'($urandom_range(0, 15)));
         run_phase(PHASE_ITEMS);
      end

      wait_drained();
      repeat (2 * PIPE_DEPTH) @(posedge clock);
      if (faults == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
